// ===== hw/rtl/slist_pkg.sv =====
// Shared types and constants for the sorted list insert/remove block.
// No dependencies; imported by slist_cell and sorted_list_insert_remove.
`timescale 1ns / 1ps

package slist_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int POS_W   = 4;
	localparam int OCNT_W  = 5;
	localparam int STAT_W  = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// per-cell control, built by the top level from the count and position
	typedef struct packed {
		logic ins_en;   // insert word accepted and store not full
		logic rem_en;   // remove word accepted and position in range
		logic valid;    // cell index below count
		logic tail;     // cell index equals count
		logic from_pos; // cell index at or above remove position
		logic at_pos;   // cell index equals remove position
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/slist_cell.sv =====
// One storage cell of the sorted chain: holds a value, compares it with the
// incoming word and shifts toward its neighbors. Depends on slist_pkg.
`timescale 1ns / 1ps

module slist_cell (
	input  logic                              clk,
	input  slist_pkg::cell_ctrl_t             ctrl,
	input  logic signed [slist_pkg::VAL_W-1:0] new_value,
	input  logic signed [slist_pkg::VAL_W-1:0] left_value,
	input  logic                              left_gt,
	input  logic signed [slist_pkg::VAL_W-1:0] right_value,
	output logic signed [slist_pkg::VAL_W-1:0] value,
	output logic                              gt,
	output logic signed [slist_pkg::VAL_W-1:0] pick
);
	import slist_pkg::*;

	logic signed [VAL_W-1:0] value_q;

	// stored value strictly above the new word; monotonic along the chain
	assign gt    = ctrl.valid && (new_value < value_q);
	assign value = value_q;
	assign pick  = ctrl.at_pos ? value_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (left_gt) begin
				value_q <= left_value;
			end else if (gt || ctrl.tail) begin
				value_q <= new_value;
			end
		end else if (ctrl.rem_en && ctrl.valid && ctrl.from_pos) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== hw/rtl/sorted_list_insert_remove.sv =====
// Sorted list with in-order insert and remove by position.
// The result is registered when the input word is accepted and shows in the next cycle.
// Throughput: one word per cycle while out_ready is high; the cell row compares and shifts in parallel.
// A waiting result does not block the next word if out_ready is high.
// Reset clears the count and the output valid; cell contents are left as is.
// Depends on slist_pkg and slist_cell.
`timescale 1ns / 1ps

module sorted_list_insert_remove (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 operation,
	input  logic signed [slist_pkg::VAL_W-1:0]   value,
	input  logic        [slist_pkg::POS_W-1:0]   position,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [slist_pkg::STAT_W-1:0]  status,
	output logic        [slist_pkg::OCNT_W-1:0]  count,
	output logic signed [slist_pkg::VAL_W-1:0]   removed_value
);
	import slist_pkg::*;

	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [OCNT_W-1:0]       count_q;
	logic signed [VAL_W-1:0] removed_q;

	logic                    accept;
	logic                    full;
	logic                    pos_ok;
	logic                    is_ins;
	logic                    is_rem;
	logic [CNT_W-1:0]        cnt_next;
	status_t                 status_next;
	logic signed [VAL_W-1:0] removed_next;

	cell_ctrl_t              ctrl   [DEPTH];
	logic signed [VAL_W-1:0] cell_v [DEPTH];
	logic                    cell_gt[DEPTH];
	logic signed [VAL_W-1:0] pick   [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (32'(cnt_q) >= 32'(DEPTH));
	assign pos_ok   = (32'(position) < 32'(cnt_q));
	assign is_ins   = accept && (op_t'(operation) == OP_INSERT) && !full;
	assign is_rem   = accept && (op_t'(operation) == OP_REMOVE) && pos_ok;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].ins_en   = is_ins;
			ctrl[i].rem_en   = is_rem;
			ctrl[i].valid    = (CNT_W'(i) < cnt_q);
			ctrl[i].tail     = (CNT_W'(i) == cnt_q);
			ctrl[i].from_pos = (32'(i) >= 32'(position));
			ctrl[i].at_pos   = (32'(i) == 32'(position));
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			slist_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[g]),
				.new_value  (value),
				.left_value ((g == 0) ? '0 : cell_v[(g == 0) ? 0 : g - 1]),
				.left_gt    ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
				.right_value(cell_v[(g == DEPTH - 1) ? g : g + 1]),
				.value      (cell_v[g]),
				.gt         (cell_gt[g]),
				.pick       (pick[g])
			);
		end
	endgenerate

	always_comb begin
		removed_next = '0;
		if (is_rem) begin
			for (int i = 0; i < DEPTH; i++) begin
				removed_next = removed_next | pick[i];
			end
		end

		cnt_next = cnt_q;
		if (is_ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (is_rem) begin
			cnt_next = cnt_q - CNT_W'(1);
		end

		if (op_t'(operation) == OP_INSERT) begin
			status_next = full ? ST_FULL : ST_DONE;
		end else begin
			status_next = pos_ok ? ST_DONE : ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_next;
			count_q   <= OCNT_W'(cnt_next);
			removed_q <= removed_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign count         = count_q;
	assign removed_value = removed_q;

endmodule
